// ===== rtl/frp_pkg.sv =====
// ----------------------------------------------------------------------------
// frp_pkg: shared types for the fasta record parser
// Parse phases, result kinds, error codes, configuration and result records.
// ----------------------------------------------------------------------------
package frp_pkg;

	localparam int unsigned DEF_W = 10;
	localparam int unsigned SEQ_W = 24;
	localparam int unsigned IDL_W = 7;

	localparam logic [DEF_W-1:0] MAX_DEF_RESET = DEF_W'(255);
	localparam logic [SEQ_W-1:0] MAX_SEQ_RESET = '1;

	// ascii codes the parser looks for
	localparam logic [7:0] CH_HEADER  = 8'h3E; // '>'
	localparam logic [7:0] CH_NEWLINE = 8'h0A; // '\n'
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_LOW_U   = 8'h75; // 'u'
	localparam logic [7:0] CH_LOW_T   = 8'h74; // 't'
	localparam logic [7:0] CH_UP_A    = 8'h41;
	localparam logic [7:0] CH_UP_Z    = 8'h5A;
	localparam logic [7:0] CH_LOW_A   = 8'h61;
	localparam logic [7:0] CH_LOW_Z   = 8'h7A;
	localparam logic [7:0] CASE_BIT   = 8'h20;

	typedef enum logic [2:0] {
		PH_HEADER   = 3'd0,
		PH_SKIP_ID  = 3'd1,
		PH_ID       = 3'd2,
		PH_SKIP_DEF = 3'd3,
		PH_DEF      = 3'd4,
		PH_SEQ      = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		K_ID_CHAR  = 3'd0,
		K_DEF_CHAR = 3'd1,
		K_SEQ_BASE = 3'd2,
		K_DONE     = 3'd3,
		K_ERROR    = 3'd4,
		K_END      = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		E_NONE       = 3'd0,
		E_NO_HEADER  = 3'd1,
		E_UNNAMED    = 3'd2,
		E_ID_NO_SEQ  = 3'd3,
		E_DEF_NO_SEQ = 3'd4
	} err_t;

	typedef struct packed {
		logic [DEF_W-1:0] max_def;
		logic [SEQ_W-1:0] max_seq;
	} frp_cfg_t;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       char_value;
		err_t             error_code;
		logic [IDL_W-1:0] id_length;
		logic [DEF_W-1:0] def_length;
		logic [SEQ_W-1:0] seq_length;
		logic             id_truncated;
		logic             def_truncated;
		logic             seq_truncated;
	} frp_result_t;

endpackage

// ===== rtl/frp_if.sv =====
// ----------------------------------------------------------------------------
// frp_if: valid/ready channels of the fasta record parser
// Byte channel into the parser and result channel out of it.
// ----------------------------------------------------------------------------
interface frp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       end_of_file;

	modport source (output valid, byte_in, end_of_file, input ready);
	modport sink   (input valid, byte_in, end_of_file, output ready);
endinterface

interface frp_result_if;
	logic                            valid;
	logic                            ready;
	frp_pkg::kind_t                  kind;
	logic [7:0]                      char_value;
	frp_pkg::err_t                   error_code;
	logic [frp_pkg::IDL_W-1:0]       id_length;
	logic [frp_pkg::DEF_W-1:0]       def_length;
	logic [frp_pkg::SEQ_W-1:0]       seq_length;
	logic                            id_truncated;
	logic                            def_truncated;
	logic                            seq_truncated;

	modport source (output valid, kind, char_value, error_code, id_length, def_length,
		seq_length, id_truncated, def_truncated, seq_truncated, input ready);
	modport sink   (input valid, kind, char_value, error_code, id_length, def_length,
		seq_length, id_truncated, def_truncated, seq_truncated, output ready);
endinterface

// ===== rtl/frp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// frp_cfg_regs: apb register file of the fasta record parser
// Holds the definition and sequence length limits, write and readback.
// ----------------------------------------------------------------------------
module frp_cfg_regs #(
	parameter int unsigned LEN_BITS = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output frp_pkg::frp_cfg_t cfg
);

	localparam logic REG_MAX_DEF = 1'b0;
	localparam logic REG_MAX_SEQ = 1'b1;

	// sequence limit keeps only LEN_BITS bits
	localparam logic [frp_pkg::SEQ_W-1:0] SEQ_MASK =
		frp_pkg::SEQ_W'((64'd1 << LEN_BITS) - 64'd1);

	frp_pkg::frp_cfg_t cfg_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_def <= frp_pkg::MAX_DEF_RESET;
			cfg_q.max_seq <= frp_pkg::MAX_SEQ_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_MAX_DEF: cfg_q.max_def <= pwdata[frp_pkg::DEF_W-1:0];
				REG_MAX_SEQ: cfg_q.max_seq <= pwdata[frp_pkg::SEQ_W-1:0] & SEQ_MASK;
				default:     cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MAX_DEF: prdata = 32'(cfg_q.max_def);
			REG_MAX_SEQ: prdata = 32'(cfg_q.max_seq);
			default:     prdata = '0;
		endcase
	end

endmodule

// ===== rtl/fasta_record_parser.sv =====
// ----------------------------------------------------------------------------
// fasta_record_parser: byte-serial fasta record parser
// Splits a text stream into identifier, definition and sequence characters
// and closes each record with a status beat carrying lengths and flags.
// ----------------------------------------------------------------------------
// a byte beat is taken into the byte register and its result beat into the result register
// throughput: one byte per cycle while the result channel takes its beats; the parse
//   state update is a combinational step between the byte register and the result register
// bytes that cause no result (blanks, dropped characters) leave no bubble
// reset: parser expects a '>' header, counts and flags clear, limits go to
//   255 definition and 16777215 sequence characters
// ----------------------------------------------------------------------------
module fasta_record_parser #(
	parameter int unsigned ID_MAX_CHARS = 64,
	parameter int unsigned LEN_BITS     = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	// byte beats in, result beats out
	frp_byte_if.sink            stream,
	frp_result_if.source        result,
	// configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	// identifier counter must reach ID_MAX_CHARS itself
	localparam int unsigned ID_W     = $clog2(ID_MAX_CHARS + 1);
	localparam int unsigned ID_EXT_W = (ID_W > frp_pkg::IDL_W) ? ID_W : frp_pkg::IDL_W;
	localparam logic [ID_W-1:0] ID_LIMIT = ID_W'(ID_MAX_CHARS);

	frp_pkg::frp_cfg_t cfg;

	frp_cfg_regs #(
		.LEN_BITS (LEN_BITS)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// ---------------------------------------------------------------- byte register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;

	// result register
	logic                 res_valid_q;
	frp_pkg::frp_result_t res_q;

	// parser state
	frp_pkg::phase_t        phase_q, phase_d;
	logic [ID_W-1:0]        id_cnt_q, id_cnt_d;
	logic [frp_pkg::DEF_W-1:0] def_cnt_q, def_cnt_d;
	logic [frp_pkg::SEQ_W-1:0] seq_cnt_q, seq_cnt_d;
	logic                   id_trunc_q, id_trunc_d;
	logic                   def_trunc_q, def_trunc_d;
	logic                   seq_trunc_q, seq_trunc_d;

	logic                 out_free;   // result register can take a new beat
	logic                 step_en;    // byte register is consumed this cycle
	logic                 emit;
	frp_pkg::frp_result_t res_d;

	assign out_free     = !res_valid_q || result.ready;
	assign step_en      = valid_s1 && out_free;
	assign stream.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			byte_s1 <= stream.byte_in;
			eof_s1  <= stream.end_of_file;
		end
	end

	// ---------------------------------------------------------------- classification
	logic is_ws, is_blank, is_upper, is_letter;
	logic [7:0] base_lc;
	logic [ID_EXT_W-1:0] id_ext;

	assign is_ws     = (byte_s1 == frp_pkg::CH_SPACE) ||
		((byte_s1 >= frp_pkg::CH_TAB) && (byte_s1 <= frp_pkg::CH_CR));
	assign is_blank  = is_ws && (byte_s1 != frp_pkg::CH_NEWLINE);
	assign is_upper  = (byte_s1 >= frp_pkg::CH_UP_A) && (byte_s1 <= frp_pkg::CH_UP_Z);
	assign is_letter = is_upper ||
		((byte_s1 >= frp_pkg::CH_LOW_A) && (byte_s1 <= frp_pkg::CH_LOW_Z));
	// lowercase by setting the case bit, then rna 'u' reads as 't'
	assign base_lc   = ((byte_s1 | frp_pkg::CASE_BIT) == frp_pkg::CH_LOW_U) ?
		frp_pkg::CH_LOW_T : (byte_s1 | frp_pkg::CASE_BIT);
	assign id_ext    = ID_EXT_W'(id_cnt_q);

	// ---------------------------------------------------------------- parse step
	always_comb begin
		phase_d     = phase_q;
		id_cnt_d    = id_cnt_q;
		def_cnt_d   = def_cnt_q;
		seq_cnt_d   = seq_cnt_q;
		id_trunc_d  = id_trunc_q;
		def_trunc_d = def_trunc_q;
		seq_trunc_d = seq_trunc_q;
		emit        = 1'b0;
		res_d       = '0;
		res_d.kind       = frp_pkg::K_ID_CHAR;
		res_d.error_code = frp_pkg::E_NONE;

		unique case (phase_q)
			frp_pkg::PH_HEADER: begin
				if (eof_s1) begin
					emit       = 1'b1;
					res_d.kind = frp_pkg::K_END;
				end else if (byte_s1 == frp_pkg::CH_HEADER) begin
					// open a new record
					phase_d     = frp_pkg::PH_SKIP_ID;
					id_cnt_d    = '0;
					def_cnt_d   = '0;
					seq_cnt_d   = '0;
					id_trunc_d  = 1'b0;
					def_trunc_d = 1'b0;
					seq_trunc_d = 1'b0;
				end else begin
					emit             = 1'b1;
					res_d.kind       = frp_pkg::K_ERROR;
					res_d.error_code = frp_pkg::E_NO_HEADER;
				end
			end

			frp_pkg::PH_SKIP_ID, frp_pkg::PH_ID: begin
				priority if (eof_s1) begin
					phase_d          = frp_pkg::PH_HEADER;
					emit             = 1'b1;
					res_d.kind       = frp_pkg::K_ERROR;
					res_d.error_code = (phase_q == frp_pkg::PH_ID) ?
						frp_pkg::E_ID_NO_SEQ : frp_pkg::E_UNNAMED;
				end else if (byte_s1 == frp_pkg::CH_NEWLINE) begin
					// newline before any identifier character names nothing
					if (phase_q == frp_pkg::PH_ID) begin
						phase_d = frp_pkg::PH_SEQ;
					end else begin
						phase_d          = frp_pkg::PH_HEADER;
						emit             = 1'b1;
						res_d.kind       = frp_pkg::K_ERROR;
						res_d.error_code = frp_pkg::E_UNNAMED;
					end
				end else if (is_ws) begin
					if (phase_q == frp_pkg::PH_ID) begin
						phase_d = frp_pkg::PH_SKIP_DEF;
					end
				end else begin
					phase_d = frp_pkg::PH_ID;
					if (id_cnt_q < ID_LIMIT) begin
						id_cnt_d         = ID_W'(id_cnt_q + 1'b1);
						emit             = 1'b1;
						res_d.kind       = frp_pkg::K_ID_CHAR;
						res_d.char_value = byte_s1;
					end else begin
						id_trunc_d = 1'b1;
					end
				end
			end

			frp_pkg::PH_SKIP_DEF, frp_pkg::PH_DEF: begin
				priority if (eof_s1) begin
					phase_d          = frp_pkg::PH_HEADER;
					emit             = 1'b1;
					res_d.kind       = frp_pkg::K_ERROR;
					res_d.error_code = frp_pkg::E_DEF_NO_SEQ;
				end else if (byte_s1 == frp_pkg::CH_NEWLINE) begin
					phase_d = frp_pkg::PH_SEQ;
				end else if (is_blank && (phase_q == frp_pkg::PH_SKIP_DEF)) begin
					phase_d = phase_q;
				end else begin
					// blanks inside the definition are kept
					phase_d = frp_pkg::PH_DEF;
					if (def_cnt_q < cfg.max_def) begin
						def_cnt_d        = frp_pkg::DEF_W'(def_cnt_q + 1'b1);
						emit             = 1'b1;
						res_d.kind       = frp_pkg::K_DEF_CHAR;
						res_d.char_value = byte_s1;
					end else begin
						def_trunc_d = 1'b1;
					end
				end
			end

			frp_pkg::PH_SEQ: begin
				priority if (eof_s1 || (byte_s1 == frp_pkg::CH_HEADER)) begin
					// close the record with the counts it had so far
					emit                = 1'b1;
					res_d.kind          = frp_pkg::K_DONE;
					res_d.id_length     = id_ext[frp_pkg::IDL_W-1:0];
					res_d.def_length    = def_cnt_q;
					res_d.seq_length    = seq_cnt_q;
					res_d.id_truncated  = id_trunc_q;
					res_d.def_truncated = def_trunc_q;
					res_d.seq_truncated = seq_trunc_q;
					if (eof_s1) begin
						phase_d = frp_pkg::PH_HEADER;
					end else begin
						// the '>' opens the next record at once
						phase_d     = frp_pkg::PH_SKIP_ID;
						id_cnt_d    = '0;
						def_cnt_d   = '0;
						seq_cnt_d   = '0;
						id_trunc_d  = 1'b0;
						def_trunc_d = 1'b0;
						seq_trunc_d = 1'b0;
					end
				end else if (!is_letter) begin
					phase_d = phase_q;
				end else if (seq_cnt_q >= cfg.max_seq) begin
					seq_trunc_d = 1'b1;
				end else begin
					seq_cnt_d        = frp_pkg::SEQ_W'(seq_cnt_q + 1'b1);
					emit             = 1'b1;
					res_d.kind       = frp_pkg::K_SEQ_BASE;
					res_d.char_value = base_lc;
				end
			end

			default: begin
				phase_d = frp_pkg::PH_HEADER;
			end
		endcase
	end

	// ---------------------------------------------------------------- state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= frp_pkg::PH_HEADER;
			id_cnt_q    <= '0;
			def_cnt_q   <= '0;
			seq_cnt_q   <= '0;
			id_trunc_q  <= 1'b0;
			def_trunc_q <= 1'b0;
			seq_trunc_q <= 1'b0;
		end else if (step_en) begin
			phase_q     <= phase_d;
			id_cnt_q    <= id_cnt_d;
			def_cnt_q   <= def_cnt_d;
			seq_cnt_q   <= seq_cnt_d;
			id_trunc_q  <= id_trunc_d;
			def_trunc_q <= def_trunc_d;
			seq_trunc_q <= seq_trunc_d;
		end
	end

	// ---------------------------------------------------------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= step_en && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && emit) begin
			res_q <= res_d;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.kind          = res_q.kind;
	assign result.char_value    = res_q.char_value;
	assign result.error_code    = res_q.error_code;
	assign result.id_length     = res_q.id_length;
	assign result.def_length    = res_q.def_length;
	assign result.seq_length    = res_q.seq_length;
	assign result.id_truncated  = res_q.id_truncated;
	assign result.def_truncated = res_q.def_truncated;
	assign result.seq_truncated = res_q.seq_truncated;

	// ---------------------------------------------------------------- assertions
	// identifier count never passes its bound
	a_id_bound: assert property (@(posedge clk) disable iff (!arst_n)
		id_cnt_q <= ID_LIMIT)
		else $error("identifier count beyond bound");

	// input stalls only when both the byte and result registers are full
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!stream.ready |-> (valid_s1 && res_valid_q))
		else $error("byte channel stalled with room to spare");

	// an error beat carries a code, every other beat carries none
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> ((res_q.kind == frp_pkg::K_ERROR) ==
			(res_q.error_code != frp_pkg::E_NONE)))
		else $error("error code does not match beat kind");

	// end of file while waiting for a header answers with an input-ended beat
	a_eof_end: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && eof_s1 && (phase_q == frp_pkg::PH_HEADER)) |=>
			(res_valid_q && (res_q.kind == frp_pkg::K_END)))
		else $error("end of file at header gave no input-ended beat");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench of the fasta record parser
// Drives byte beats with random gaps into the parser and predicts each result
// beat from its own copy of the parse state. A checker compares every result
// beat, field by field, with the oldest predicted one. The limits are
// reprogrammed over the apb port between phases of the run.
// ----------------------------------------------------------------------------
module tb;
	import frp_pkg::*;

	localparam int unsigned ID_BOUND       = 64;
	localparam int          WATCHDOG_LIMIT = 4000;
	localparam int          TAIL_CYCLES    = 8;
	localparam int          RANDOM_BYTES   = 900;
	localparam int          PHASES         = 6;
	localparam int          HOLD_CYCLES    = 300;

	// register byte addresses
	localparam logic [2:0] ADDR_MAX_DEF = 3'd0;
	localparam logic [2:0] ADDR_MAX_SEQ = 3'd4;

	// whitespace codes the package does not name
	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [2:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;

	frp_byte_if   byte_ch ();
	frp_result_if result_ch ();

	fasta_record_parser dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.stream  (byte_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #1 clk = ~clk;

	// shared run state
	int  mismatches    = 0;
	int  bytes_sent    = 0;
	int  stall_request = 0;
	bit  idle_on       = 1'b1;

	// result beats still owed by the parser, oldest first
	frp_result_t pending_beats[$];

	// predicted parser state and limits
	phase_t            ph       = PH_HEADER;
	logic [6:0]        id_cnt   = '0;
	logic [DEF_W-1:0]  def_cnt  = '0;
	logic [SEQ_W-1:0]  seq_cnt  = '0;
	logic              id_trunc  = 1'b0;
	logic              def_trunc = 1'b0;
	logic              seq_trunc = 1'b0;
	logic [DEF_W-1:0]  lim_def  = MAX_DEF_RESET;
	logic [SEQ_W-1:0]  lim_seq  = MAX_SEQ_RESET;

	// ------------------------------------------------------------------------
	// character classes
	// ------------------------------------------------------------------------
	function automatic bit is_space(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic bit is_letter(input logic [7:0] c);
		return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LOW_A && c <= CH_LOW_Z);
	endfunction

	// ------------------------------------------------------------------------
	// parse prediction: one byte beat in, zero or one result beat owed
	// ------------------------------------------------------------------------
	function automatic void start_record();
		ph        = PH_SKIP_ID;
		id_cnt    = '0;
		def_cnt   = '0;
		seq_cnt   = '0;
		id_trunc  = 1'b0;
		def_trunc = 1'b0;
		seq_trunc = 1'b0;
	endfunction

	function automatic void advance_parser(input logic [7:0] c, input logic eof);
		frp_result_t r;
		bit          emit;
		logic [7:0]  b;
		r    = '0;
		emit = 1'b0;
		b    = c;
		case (ph)
			PH_HEADER: begin
				if (eof) begin
					r.kind = K_END;
					emit   = 1'b1;
				end else if (b == CH_HEADER) begin
					start_record();
				end else begin
					r.kind       = K_ERROR;
					r.error_code = E_NO_HEADER;
					emit         = 1'b1;
				end
			end
			PH_SKIP_ID, PH_ID: begin
				if (eof) begin
					// nothing named yet versus a name with no sequence
					r.kind       = K_ERROR;
					r.error_code = (ph == PH_SKIP_ID) ? E_UNNAMED : E_ID_NO_SEQ;
					emit         = 1'b1;
					ph           = PH_HEADER;
				end else if (b == CH_NEWLINE) begin
					if (ph == PH_SKIP_ID) begin
						r.kind       = K_ERROR;
						r.error_code = E_UNNAMED;
						emit         = 1'b1;
						ph           = PH_HEADER;
					end else begin
						ph = PH_SEQ;
					end
				end else if (is_space(b)) begin
					// leading blanks skipped, a blank after the name ends it
					if (ph == PH_ID)
						ph = PH_SKIP_DEF;
				end else begin
					ph = PH_ID;
					if (id_cnt < 7'(ID_BOUND)) begin
						id_cnt       = id_cnt + 1'b1;
						r.kind       = K_ID_CHAR;
						r.char_value = b;
						emit         = 1'b1;
					end else begin
						id_trunc = 1'b1;
					end
				end
			end
			PH_SKIP_DEF, PH_DEF: begin
				if (eof) begin
					r.kind       = K_ERROR;
					r.error_code = E_DEF_NO_SEQ;
					emit         = 1'b1;
					ph           = PH_HEADER;
				end else if (b == CH_NEWLINE) begin
					ph = PH_SEQ;
				end else if (ph == PH_SKIP_DEF && is_space(b)) begin
					// blanks before the definition are dropped
				end else begin
					// blanks inside the definition are kept
					ph = PH_DEF;
					if (def_cnt < lim_def) begin
						def_cnt      = def_cnt + 1'b1;
						r.kind       = K_DEF_CHAR;
						r.char_value = b;
						emit         = 1'b1;
					end else begin
						def_trunc = 1'b1;
					end
				end
			end
			PH_SEQ: begin
				if (eof || b == CH_HEADER) begin
					r.kind          = K_DONE;
					r.id_length     = id_cnt;
					r.def_length    = def_cnt;
					r.seq_length    = seq_cnt;
					r.id_truncated  = id_trunc;
					r.def_truncated = def_trunc;
					r.seq_truncated = seq_trunc;
					emit            = 1'b1;
					// a header byte opens the next record at once
					if (eof)
						ph = PH_HEADER;
					else
						start_record();
				end else if (is_letter(b)) begin
					if (seq_cnt >= lim_seq) begin
						seq_trunc = 1'b1;
					end else begin
						seq_cnt = seq_cnt + 1'b1;
						if (b <= CH_UP_Z)
							b = b | CASE_BIT;
						if (b == CH_LOW_U)
							b = CH_LOW_T;
						r.kind       = K_SEQ_BASE;
						r.char_value = b;
						emit         = 1'b1;
					end
				end
			end
			default: begin
				ph = PH_HEADER;
			end
		endcase
		if (emit)
			pending_beats.push_back(r);
	endfunction

	// ------------------------------------------------------------------------
	// mismatch reporting
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	// ------------------------------------------------------------------------
	// result checker: every accepted result beat against the oldest owed one
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		frp_result_t want;
		if (result_ch.valid && result_ch.ready) begin
			if (pending_beats.size() == 0) begin
				report_mismatch($sformatf("result beat kind %0d with nothing owed",
					result_ch.kind));
			end else begin
				want = pending_beats.pop_front();
				check_field("kind", 32'(result_ch.kind), 32'(want.kind));
				check_field("char_value", 32'(result_ch.char_value),
					32'(want.char_value));
				check_field("error_code", 32'(result_ch.error_code),
					32'(want.error_code));
				check_field("id_length", 32'(result_ch.id_length), 32'(want.id_length));
				check_field("def_length", 32'(result_ch.def_length),
					32'(want.def_length));
				check_field("seq_length", 32'(result_ch.seq_length),
					32'(want.seq_length));
				check_field("id_truncated", 32'(result_ch.id_truncated),
					32'(want.id_truncated));
				check_field("def_truncated", 32'(result_ch.def_truncated),
					32'(want.def_truncated));
				check_field("seq_truncated", 32'(result_ch.seq_truncated),
					32'(want.seq_truncated));
			end
		end
	end

	// ------------------------------------------------------------------------
	// watchdog: ends the run when no beat moves for too long
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : watchdog
		int quiet;
		if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)
			|| (psel && penable))
			quiet = 0;
		else
			quiet = quiet + 1;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat moved for %0d cycles", quiet);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// wait drawn per beat, zero while idling is switched off
	function automatic int pick_gap();
		return idle_on ? $urandom_range(0, 10) : 0;
	endfunction

	// ------------------------------------------------------------------------
	// receiver pacing: a random wait before each result beat, plus a long
	// hold-off on request that lets the parser fill up and stall its input
	// ------------------------------------------------------------------------
	initial begin : result_pacing
		int gap;
		int hold;
		gap  = 0;
		hold = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready)
				gap = pick_gap();
			if (stall_request > 0) begin
				hold          = stall_request;
				stall_request = 0;
			end
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				result_ch.ready <= 1'b0;
			end else if (gap > 0) begin
				gap--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// byte sender: one beat, after a random gap, predicted on acceptance
	// ------------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b, input logic eof);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_ch.valid       <= 1'b1;
		byte_ch.byte_in     <= b;
		byte_ch.end_of_file <= eof;
		do
			@(posedge clk);
		while (!byte_ch.ready);
		advance_parser(b, eof);
		bytes_sent++;
	endtask

	// end of input beat, the byte rides along as noise
	task automatic send_eof();
		send_byte(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// stop offering, then wait for every owed beat and the pipeline tail
	task automatic wait_drained();
		@(negedge clk);
		byte_ch.valid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// apb write: setup cycle then access cycle
	task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (addr == ADDR_MAX_DEF)
			lim_def = value[DEF_W-1:0];
		else
			lim_seq = value[SEQ_W-1:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// limits only change while the parser is idle
	task automatic set_limits(input int unsigned def_max, input int unsigned seq_max);
		wait_drained();
		reg_write(ADDR_MAX_DEF, def_max);
		reg_write(ADDR_MAX_SEQ, seq_max);
	endtask

	// ------------------------------------------------------------------------
	// random text pieces
	// ------------------------------------------------------------------------
	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 4))
			0:       return CH_TAB;
			1:       return CH_CR;
			2:       return CH_VT;
			3:       return CH_FF;
			default: return CH_SPACE;
		endcase
	endfunction

	function automatic logic [7:0] pick_id_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (is_space(c));
		return c;
	endfunction

	function automatic logic [7:0] pick_def_char();
		logic [7:0] c;
		if ($urandom_range(0, 7) == 0)
			return pick_blank();
		do
			c = 8'($urandom_range(0, 255));
		while (c == CH_NEWLINE);
		return c;
	endfunction

	function automatic logic [7:0] pick_seq_char();
		string      bases;
		logic [7:0] c;
		bases = "ACGTUacgtu";
		if ($urandom_range(0, 99) < 85)
			return bases[$urandom_range(0, 9)];
		// other bytes but '>': digits, blanks, newlines, high bytes are dropped, letters count
		do
			c = 8'($urandom_range(0, 255));
		while (c == CH_HEADER);
		return c;
	endfunction

	// well-formed record; ends on eof or is left open for the next header
	task automatic send_record(input int id_len, input int def_len, input int seq_len,
		input bit to_eof);
		send_byte(CH_HEADER, 1'b0);
		repeat ($urandom_range(0, 2)) send_byte(pick_blank(), 1'b0);
		repeat (id_len) send_byte(pick_id_char(), 1'b0);
		if (def_len > 0 || $urandom_range(0, 1)) begin
			repeat ($urandom_range(1, 2)) send_byte(pick_blank(), 1'b0);
			repeat (def_len) send_byte(pick_def_char(), 1'b0);
		end
		send_byte(CH_NEWLINE, 1'b0);
		repeat (seq_len) send_byte(pick_seq_char(), 1'b0);
		if (to_eof)
			send_eof();
	endtask

	// header then a few mixed bytes cut off by eof
	task automatic send_broken_record();
		send_byte(CH_HEADER, 1'b0);
		repeat ($urandom_range(0, 5)) begin
			case ($urandom_range(0, 3))
				0:       send_byte(pick_blank(), 1'b0);
				1:       send_byte(CH_NEWLINE, 1'b0);
				default: send_byte(pick_id_char(), 1'b0);
			endcase
		end
		send_eof();
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 4)) begin
			case ($urandom_range(0, 9))
				0, 1:    send_eof();
				2, 3:    send_byte(CH_HEADER, 1'b0);
				default: send_byte(8'($urandom_range(0, 255)), 1'b0);
			endcase
		end
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// every error code and the end marker while expecting a header
	task automatic test_header_errors();
		send_byte("x", 1'b0);          // missing header marker
		send_eof();                    // end while expecting a header
		send_byte(CH_HEADER, 1'b0);    // newline before any name
		send_byte(CH_NEWLINE, 1'b0);
		send_byte(CH_HEADER, 1'b0);    // end of file before any name
		send_byte(CH_SPACE, 1'b0);
		send_eof();
		send_byte(CH_HEADER, 1'b0);    // nul is an ordinary name char, then eof
		send_byte(8'h00, 1'b0);
		send_eof();
		send_byte(CH_HEADER, 1'b0);    // eof while skipping to the definition
		send_byte("a", 1'b0);
		send_byte(CH_SPACE, 1'b0);
		send_eof();
		send_byte(CH_HEADER, 1'b0);    // eof inside the definition
		send_byte("a", 1'b0);
		send_byte(CH_TAB, 1'b0);
		send_byte("d", 1'b0);
		send_eof();
	endtask

	// two records: case folding, u to t, dropped bytes, header ends a record
	task automatic test_basic_record();
		send_byte(CH_HEADER, 1'b0);
		send_byte(CH_SPACE, 1'b0);
		send_byte("I", 1'b0);
		send_byte(CH_SPACE, 1'b0);
		send_byte("d", 1'b0);
		send_byte(CH_TAB, 1'b0);       // blank kept inside the definition
		send_byte("e", 1'b0);
		send_byte(CH_NEWLINE, 1'b0);
		send_byte("A", 1'b0);
		send_byte("U", 1'b0);
		send_byte("u", 1'b0);
		send_byte("7", 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte("Z", 1'b0);
		send_byte(CH_HEADER, 1'b0);    // record done, next record opens
		send_byte("q", 1'b0);
		send_byte(CH_NEWLINE, 1'b0);
		send_eof();                    // record done with an empty sequence
		send_eof();                    // then the end marker
	endtask

	// zero definition and sequence bounds keep no such characters and any one sets its flag
	task automatic test_zero_bounds();
		set_limits(0, 0);
		send_byte(CH_HEADER, 1'b0);
		send_byte("a", 1'b0);
		send_byte(CH_SPACE, 1'b0);
		send_byte("d", 1'b0);
		send_byte(CH_NEWLINE, 1'b0);
		send_byte("g", 1'b0);
		send_eof();
		set_limits(32'(MAX_DEF_RESET), 32'(MAX_SEQ_RESET));
	endtask

	// receiver holds off while the sender keeps offering the bytes of a record
	task automatic test_backpressure();
		idle_on       = 1'b0;
		stall_request = HOLD_CYCLES;
		send_record(3, 4, 40, 1'b1);
		idle_on = 1'b1;
	endtask

	// random records, noise and broken records over several limit settings
	task automatic test_random_stream();
		int unsigned def_set[PHASES];
		int unsigned seq_set[PHASES];
		int          start;
		int          pick;
		int          id_len;
		int          def_len;
		int          seq_len;
		def_set = '{255, 0, 1023, 3, 1, 20};
		seq_set = '{16777215, 0, 16777215, 10, 1, 100};
		for (int p = 0; p < PHASES; p++) begin
			set_limits(def_set[p], seq_set[p]);
			start = bytes_sent;
			while (bytes_sent - start < RANDOM_BYTES / PHASES) begin
				// some stretches run with no idling on either side
				idle_on = ($urandom_range(0, 3) != 0);
				pick    = $urandom_range(0, 99);
				if (pick < 75) begin
					id_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70)
						: $urandom_range(1, 8);
					def_len = ($urandom_range(0, 9) < 4) ? 0
						: ($urandom_range(0, 1) ? $urandom_range(1, 6) : $urandom_range(1, 30));
					seq_len = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 30);
					send_record(id_len, def_len, seq_len, $urandom_range(0, 99) < 15);
				end else if (pick < 87) begin
					send_noise();
				end else begin
					send_broken_record();
				end
			end
		end
		idle_on = 1'b1;
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		byte_ch.valid       = 1'b0;
		byte_ch.byte_in     = '0;
		byte_ch.end_of_file = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_header_errors();
		test_basic_record();
		test_zero_bounds();
		test_backpressure();
		test_random_stream();

		wait_drained();
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
